FILE: sv/c2s_pkg.sv
// Package for the Cartesian to spherical converter: widths, constants, arctangent table.
package c2s_pkg;

	localparam int CoordW = 24;
	localparam int Iters  = 20;
	localparam int Guard  = 24;
	// datapath width: magnitude with guard bits plus CORDIC growth and sign
	localparam int DW     = CoordW + Guard + 3;
	localparam int AccW   = 34;
	localparam int SumW   = 2 * CoordW + 2;
	localparam int RootW  = SumW / 2;
	localparam logic [31:0] InvGain = 32'd2608131496;
	localparam logic [24:0] Deg90   = 25'(90 << 16);
	localparam logic [24:0] Deg180  = 25'(180 << 16);
	localparam logic [24:0] Deg360  = 25'(360 << 16);

	typedef logic signed [DW-1:0] dat_t;
	typedef logic signed [AccW-1:0] acc_t;

	// atan(2^-i) in degrees scaled by 2^24
	function automatic acc_t atan_deg(input int i);
		acc_t r;
		begin
			case (i)
				0: r = 34'sd754974720;  1: r = 34'sd445687602;  2: r = 34'sd235489088;
				3: r = 34'sd119537938;  4: r = 34'sd60000934;   5: r = 34'sd30029717;
				6: r = 34'sd15018523;   7: r = 34'sd7509720;    8: r = 34'sd3754917;
				9: r = 34'sd1877466;    10: r = 34'sd938734;    11: r = 34'sd469367;
				12: r = 34'sd234684;    13: r = 34'sd117342;    14: r = 34'sd58671;
				15: r = 34'sd29335;     16: r = 34'sd14668;     17: r = 34'sd7334;
				18: r = 34'sd3667;      19: r = 34'sd1833;      20: r = 34'sd917;
				21: r = 34'sd458;       22: r = 34'sd229;       23: r = 34'sd115;
				24: r = 34'sd57;        25: r = 34'sd29;        26: r = 34'sd14;
				27: r = 34'sd7;         28: r = 34'sd4;         29: r = 34'sd2;
				30: r = 34'sd1;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

FILE: sv/cartesian_to_spherical_core.sv
// Cartesian to spherical converter: square root, two CORDIC vectoring passes, quadrant fold.
// Pipeline: 3 + Iters + 2 + Iters + 4 = 49 register stages; the square root steps run
// alongside the CORDIC stages.
// Throughput: one request per cycle when not stalled; every stage is one register with a valid bit,
// and a stall freezes the whole pipe so nothing is lost or repeated.
// Reset: arst_n clears all valid bits asynchronously; payload registers are not reset.
module cartesian_to_spherical_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // coord_x, coord_y, coord_z
	input  logic        s_tuser,   // three_d
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata    // radius, azimuth, polar_angle, polar_valid, zero_vector
);
	localparam int CW = c2s_pkg::CoordW;
	localparam int DW = c2s_pkg::DW;
	localparam int AW = c2s_pkg::AccW;
	localparam int N  = c2s_pkg::Iters;
	localparam int SW = c2s_pkg::SumW;
	localparam int RW = c2s_pkg::RootW;
	// stage plan: 0 input, 1 abs, 2 squares, 3 sum; CORDIC A: N iterations then
	// gain mul (2 stages); CORDIC B: N iterations then angle; then 3 fold stages
	localparam int PA = 3;            // first CORDIC A stage index
	localparam int PB = PA + N + 2;   // first CORDIC B stage index
	localparam int PE = PB + N;       // end of CORDIC B
	localparam int L  = PE + 4;       // total stages

	logic adv;
	logic [L-1:0] v;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v <= '0;
		else if (adv) v <= {v[L-2:0], s_tvalid};
	end

	// ---------- front: absolute values and sum of squares ----------
	logic [CW-1:0] ax_s1, ay_s1, az_s1;
	logic sx_s1, sy_s1, sz_s1, td_s1, zr_s1;
	logic [2*CW-1:0] px_s2, py_s2, pz_s2;
	logic [CW-1:0] ax_s2, ay_s2, az_s2;
	logic sx_s2, sy_s2, sz_s2, td_s2, zr_s2;
	logic [SW-1:0] sum_s3;
	logic [CW-1:0] ax_s3, ay_s3, az_s3;
	logic sx_s3, sy_s3, sz_s3, td_s3, zr_s3;

	logic signed [CW-1:0] ix, iy, iz;
	assign ix = s_tdata[CW-1:0];
	assign iy = s_tdata[2*CW-1:CW];
	assign iz = s_tuser ? s_tdata[3*CW-1:2*CW] : '0;

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1 <= ix[CW-1]; sy_s1 <= iy[CW-1]; sz_s1 <= iz[CW-1];
			ax_s1 <= ix[CW-1] ? CW'(-ix) : CW'(ix);
			ay_s1 <= iy[CW-1] ? CW'(-iy) : CW'(iy);
			az_s1 <= iz[CW-1] ? CW'(-iz) : CW'(iz);
			td_s1 <= s_tuser;
			zr_s1 <= (ix == '0) && (iy == '0) && (iz == '0);
			px_s2 <= ax_s1 * ax_s1; py_s2 <= ay_s1 * ay_s1; pz_s2 <= az_s1 * az_s1;
			ax_s2 <= ax_s1; ay_s2 <= ay_s1; az_s2 <= az_s1;
			sx_s2 <= sx_s1; sy_s2 <= sy_s1; sz_s2 <= sz_s1; td_s2 <= td_s1; zr_s2 <= zr_s1;
			sum_s3 <= SW'(px_s2) + SW'(py_s2) + SW'(pz_s2);
			ax_s3 <= ax_s2; ay_s3 <= ay_s2; az_s3 <= az_s2;
			sx_s3 <= sx_s2; sy_s3 <= sy_s2; sz_s3 <= sz_s2; td_s3 <= td_s2; zr_s3 <= zr_s2;
		end
	end

	// ---------- square root: one result bit per stage, RW stages from stage 3 ----------
	logic [SW-1:0] rm_q [RW+1];
	logic [RW-1:0] rr_q [RW+1];
	assign rm_q[0] = sum_s3;
	assign rr_q[0] = '0;
	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [SW-1:0] rem_sk;
		logic [RW-1:0] root_sk;
		logic [SW+1:0] trial;
		logic [SW+1:0] cand;
		localparam int B = RW - 1 - k;
		// (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
		assign cand  = ((SW+2)'(rr_q[k]) << (B + 1)) + ((SW+2)'(1) << (2 * B));
		assign trial = (SW+2)'(rm_q[k]);
		always_ff @(posedge clk) begin
			if (adv) begin
				if (trial >= cand) begin
					rem_sk  <= SW'(trial - cand);
					root_sk <= rr_q[k] | (RW'(1) << B);
				end else begin
					rem_sk  <= rm_q[k];
					root_sk <= rr_q[k];
				end
			end
		end
		assign rm_q[k+1] = rem_sk;
		assign rr_q[k+1] = root_sk;
	end
	// root settles at stage 3+RW; carry it forward to the end with rounding
	localparam int RD = L - 3 - RW;
	logic [23:0] rad_q [RD+1];
	logic [RW:0] rnd;
	assign rnd = (RW+1)'(rr_q[RW]) + ((rm_q[RW] > SW'(rr_q[RW])) ? 1'b1 : 1'b0);
	assign rad_q[0] = (rnd > 24'hFFFFFF) ? 24'hFFFFFF : rnd[23:0];
	for (genvar k = 0; k < RD; k++) begin : g_rdl
		logic [23:0] r_sk;
		always_ff @(posedge clk) if (adv) r_sk <= rad_q[k];
		assign rad_q[k+1] = r_sk;
	end

	// ---------- CORDIC A: atan2(ay, ax) ----------
	typedef struct packed {
		logic sx, sy, sz, td, zr;
		logic [CW-1:0] az;
	} side_t;

	c2s_pkg::dat_t ax_a [N+1], ay_a [N+1];
	c2s_pkg::acc_t ac_a [N+1];
	side_t sd_a [N+1];
	logic az0_a [N+1], bz0_a [N+1];
	assign ax_a[0] = DW'({ax_s3, {c2s_pkg::Guard{1'b0}}});
	assign ay_a[0] = DW'({ay_s3, {c2s_pkg::Guard{1'b0}}});
	assign ac_a[0] = '0;
	assign sd_a[0] = '{sx_s3, sy_s3, sz_s3, td_s3, zr_s3, az_s3};
	assign az0_a[0] = (ax_s3 == '0);
	assign bz0_a[0] = (ay_s3 == '0);
	for (genvar i = 0; i < N; i++) begin : g_ca
		c2s_pkg::dat_t xs, ys;
		c2s_pkg::acc_t as;
		side_t ss;
		logic a0, b0;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!ay_a[i][DW-1]) begin
					xs <= ax_a[i] + (ay_a[i] >>> i);
					ys <= ay_a[i] - (ax_a[i] >>> i);
					as <= ac_a[i] + c2s_pkg::atan_deg(i);
				end else begin
					xs <= ax_a[i] - (ay_a[i] >>> i);
					ys <= ay_a[i] + (ax_a[i] >>> i);
					as <= ac_a[i] - c2s_pkg::atan_deg(i);
				end
				ss <= sd_a[i]; a0 <= az0_a[i]; b0 <= bz0_a[i];
			end
		end
		assign ax_a[i+1] = xs; assign ay_a[i+1] = ys; assign ac_a[i+1] = as;
		assign sd_a[i+1] = ss; assign az0_a[i+1] = a0; assign bz0_a[i+1] = b0;
	end

	// angle of A and gain correction (split multiply, two stages)
	function automatic logic [24:0] fin_angle(input c2s_pkg::acc_t acc, input logic a0,
			input logic b0);
		logic [AW-1:0] q;
		begin
			q = AW'((acc + AW'(128)) >>> 8);
			if (b0) return '0;
			if (a0) return c2s_pkg::Deg90;
			if (acc[AW-1]) return '0;
			if (q > AW'(c2s_pkg::Deg90)) return c2s_pkg::Deg90;
			return q[24:0];
		end
	endfunction

	logic [24:0] ta_g1, ta_g2;
	logic [DW-1:0] hi_g1, lo_g1;  // products of gain with high and low words
	logic use0_g1;
	side_t sd_g1, sd_g2;
	localparam int HW = DW - 32;
	logic [HW+31:0] ph;
	logic [63:0] pl;
	assign ph = ax_a[N][DW-1:32] * c2s_pkg::InvGain;
	assign pl = ax_a[N][31:0] * c2s_pkg::InvGain;
	always_ff @(posedge clk) begin
		if (adv) begin
			ta_g1   <= fin_angle(ac_a[N], az0_a[N], bz0_a[N]);
			hi_g1   <= DW'(ph);
			lo_g1   <= DW'(pl[63:32]);
			use0_g1 <= az0_a[N] || bz0_a[N];
			sd_g1   <= sd_a[N];
			ta_g2   <= ta_g1;
			sd_g2   <= sd_g1;
		end
	end
	// exact magnitude for axis cases travels separately
	logic [DW-1:0] ex_q [N+2];
	assign ex_q[0] = az0_a[0] ? ay_a[0] : ax_a[0];
	for (genvar i = 0; i < N + 1; i++) begin : g_ex
		logic [DW-1:0] e;
		always_ff @(posedge clk) if (adv) e <= ex_q[i];
		assign ex_q[i+1] = e;
	end
	c2s_pkg::dat_t rho_b;
	logic [DW-1:0] rho_sel;
	assign rho_sel = use0_g1 ? ex_q[N+1] : hi_g1 + lo_g1;
	always_ff @(posedge clk) if (adv) rho_b <= rho_sel;

	// ---------- CORDIC B: atan2(rho, az) ----------
	c2s_pkg::dat_t bx [N+1], by [N+1];
	c2s_pkg::acc_t bc [N+1];
	side_t sd_b [N+1];
	logic [24:0] ta_b [N+1];
	logic a0_b [N+1], b0_b [N+1];
	assign bx[0] = DW'({sd_g2.az, {c2s_pkg::Guard{1'b0}}});
	assign by[0] = rho_b;
	assign bc[0] = '0;
	assign sd_b[0] = sd_g2;
	assign ta_b[0] = ta_g2;
	assign a0_b[0] = (sd_g2.az == '0);
	assign b0_b[0] = (rho_b == '0);
	for (genvar i = 0; i < N; i++) begin : g_cb
		c2s_pkg::dat_t xs, ys;
		c2s_pkg::acc_t as;
		side_t ss;
		logic [24:0] tt;
		logic a0, b0;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!by[i][DW-1]) begin
					xs <= bx[i] + (by[i] >>> i);
					ys <= by[i] - (bx[i] >>> i);
					as <= bc[i] + c2s_pkg::atan_deg(i);
				end else begin
					xs <= bx[i] - (by[i] >>> i);
					ys <= by[i] + (bx[i] >>> i);
					as <= bc[i] - c2s_pkg::atan_deg(i);
				end
				ss <= sd_b[i]; tt <= ta_b[i]; a0 <= a0_b[i]; b0 <= b0_b[i];
			end
		end
		assign bx[i+1] = xs; assign by[i+1] = ys; assign bc[i+1] = as;
		assign sd_b[i+1] = ss; assign ta_b[i+1] = tt;
		assign a0_b[i+1] = a0; assign b0_b[i+1] = b0;
	end

	// ---------- fold stages ----------
	logic [24:0] tp_e1, ta_e1;
	side_t sd_e1;
	logic [24:0] az_e2;
	logic [23:0] po_e2;
	logic pv_e2, zr_e2;
	logic [24:0] az_e3;
	logic [23:0] po_e3;
	logic pv_e3, zr_e3;
	logic [24:0] az_e4;
	logic [23:0] po_e4;
	logic pv_e4, zr_e4;
	logic [24:0] azc;
	logic [24:0] poc;
	always_comb begin
		if (!sd_e1.sx && !sd_e1.sy) azc = ta_e1;
		else if (sd_e1.sx && !sd_e1.sy) azc = c2s_pkg::Deg180 - ta_e1;
		else if (sd_e1.sx) azc = c2s_pkg::Deg180 + ta_e1;
		else azc = (ta_e1 == '0) ? '0 : c2s_pkg::Deg360 - ta_e1;
		if (sd_e1.zr) azc = '0;
		poc = sd_e1.sz ? c2s_pkg::Deg180 - tp_e1 : tp_e1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			tp_e1 <= fin_angle(bc[N], a0_b[N], b0_b[N]);
			ta_e1 <= ta_b[N];
			sd_e1 <= sd_b[N];
			az_e2 <= azc;
			pv_e2 <= sd_e1.td && !sd_e1.zr;
			po_e2 <= (sd_e1.td && !sd_e1.zr) ? poc[23:0] : '0;
			zr_e2 <= sd_e1.zr;
			az_e3 <= az_e2; po_e3 <= po_e2; pv_e3 <= pv_e2; zr_e3 <= zr_e2;
			az_e4 <= az_e3; po_e4 <= po_e3; pv_e4 <= pv_e3; zr_e4 <= zr_e3;
		end
	end

	assign m_tvalid = v[L-1];
	assign m_tdata  = {5'd0, zr_e4, pv_e4, po_e4, az_e4, rad_q[RD]};

	ast_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	ast_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[74] |-> m_tdata[48:24] == '0 && !m_tdata[73])
		else $error("origin with nonzero azimuth or valid polar");
	ast_az: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[48:24] < c2s_pkg::Deg360)
		else $error("azimuth out of range");
	ast_pol: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[73] |-> m_tdata[72:49] == '0)
		else $error("polar angle without valid");
endmodule
